// ===== hdl/wsfu_pkg.sv =====
`timescale 1ns / 1ps

package wsfu_pkg;

    // Result kinds carried on m_tuser
    typedef enum logic [1:0] {
        KIND_PAYLOAD     = 2'd0,
        KIND_EMPTY_FRAME = 2'd1,
        KIND_CLOSE       = 2'd2,
        KIND_UNSUPPORTED = 2'd3
    } kind_t;

    localparam int BYTE_W   = 8;
    localparam int LENGTH_W = 64;
    localparam int MASK_W   = 32;
    localparam int FB_W     = 16;
    localparam int HCNT_W   = 4;
    localparam int KIND_W   = 2;
    localparam int S_TDATA_W = BYTE_W;
    localparam int M_TDATA_W = BYTE_W + LENGTH_W;

    // Header byte fields
    localparam logic [7:0] FIN_BIT     = 8'h80;
    localparam logic [7:0] OPCODE_MASK = 8'h0f;
    localparam logic [7:0] MASK_BIT    = 8'h80;
    localparam logic [7:0] LEN7_MASK   = 8'h7f;
    localparam logic [3:0] OP_BINARY   = 4'h2;
    localparam logic [3:0] OP_CLOSE    = 4'h8;

    // 7-bit length codes announcing an extended length
    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // Extended length byte counts and header byte counts
    localparam logic [HCNT_W-1:0] EXT_NONE      = 4'd0;
    localparam logic [HCNT_W-1:0] EXT_16        = 4'd2;
    localparam logic [HCNT_W-1:0] EXT_64        = 4'd8;
    localparam logic [HCNT_W-1:0] HDR_CHECK_CNT = 4'd6;
    localparam logic [HCNT_W-1:0] HDR_MAX_CNT   = 4'd14;

endpackage

// ===== hdl/websocket_frame_unmasker.sv =====
`timescale 1ns / 1ps
// A result is registered and appears on the m_ side in the cycle after the byte that causes it.
// Throughput: one byte per cycle; each byte is parsed in one pass and the output register
//   refills as it drains, so s_tready only drops while a result is held by m_tready low.
// Reset: aresetn is synchronous, active low; it returns the parser to the start of a
//   frame header, clears a halt and drops any pending result.
module websocket_frame_unmasker
    import wsfu_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] data_byte
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] payload_byte, [71:8] payload_length
    output logic [KIND_W-1:0]    m_tuser,   // [1:0] kind
    output logic                 m_tlast    // last_byte
);

    // Parser phase; the fourth code is treated as halted
    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALT    = 2'd2,
        PH_SPARE   = 2'd3
    } phase_t;

    phase_t               phase_reg,        phase_next;
    logic [HCNT_W-1:0]    header_count_reg, header_count_next;
    logic [FB_W-1:0]      first_bytes_reg,  first_bytes_next;
    logic [LENGTH_W-1:0]  length_reg,       length_next;
    logic [MASK_W-1:0]    mask_reg,         mask_next;
    logic [LENGTH_W-1:0]  payload_left_reg, payload_left_next;
    logic [1:0]           mask_phase_reg,   mask_phase_next;

    // Output register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic [KIND_W-1:0]    out_kind_reg;
    logic                 out_last_reg;

    // Result produced by the current transaction
    logic                 emit;
    kind_t                res_kind;
    logic [BYTE_W-1:0]    res_byte;
    logic                 res_last;
    logic [LENGTH_W-1:0]  res_len;

    logic                 s_accept;
    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    mbyte;
    logic [4:0]           mshift;
    logic [LENGTH_W-1:0]  left_dec;
    logic [6:0]           len7;
    logic [HCNT_W-1:0]    ext;
    logic [HCNT_W-1:0]    cnt;
    logic [7:0]           b0;
    logic                 fin;
    logic                 masked;
    logic [3:0]           opcode;

    // A new byte is taken whenever the output register is empty or being drained
    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign b        = s_tdata;

    // Mask byte for the current payload index; first mask byte sits in the top bits
    assign mshift   = {~mask_phase_reg, 3'b000};
    assign mbyte    = BYTE_W'(mask_reg >> mshift);
    assign left_dec = payload_left_reg - LENGTH_W'(1);

    always_comb begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        first_bytes_next  = first_bytes_reg;
        length_next       = length_reg;
        mask_next         = mask_reg;
        payload_left_next = payload_left_reg;
        mask_phase_next   = mask_phase_reg;
        emit     = 1'b0;
        res_kind = KIND_PAYLOAD;
        res_byte = '0;
        res_last = 1'b0;
        res_len  = '0;
        len7     = '0;
        ext      = EXT_NONE;
        cnt      = '0;
        b0       = '0;
        fin      = 1'b0;
        masked   = 1'b0;
        opcode   = '0;

        case (phase_reg)
            PH_PAYLOAD: begin
                payload_left_next = left_dec;
                mask_phase_next   = mask_phase_reg + 2'd1;
                emit     = 1'b1;
                res_kind = KIND_PAYLOAD;
                res_byte = b ^ mbyte;
                res_len  = length_reg;
                res_last = (left_dec == '0);
                if (res_last) begin
                    phase_next        = PH_HEADER;
                    header_count_next = '0;
                end
            end
            PH_HEADER: begin
                if (header_count_reg == 4'd0) begin
                    first_bytes_next = {b, 8'h00};
                    length_next      = '0;
                    mask_next        = '0;
                end else if (header_count_reg == 4'd1) begin
                    first_bytes_next = {first_bytes_reg[15:8], b};
                end

                len7 = first_bytes_next[6:0] & LEN7_MASK[6:0];
                if (len7 == LEN7_EXT16) begin
                    ext = EXT_16;
                end else if (len7 == LEN7_EXT64) begin
                    ext = EXT_64;
                end else begin
                    ext = EXT_NONE;
                end

                // Bytes after the first two: extended length first, then the mask key
                if (header_count_reg >= 4'd2) begin
                    if ((header_count_reg - 4'd2) < ext) begin
                        length_next = {length_next[LENGTH_W-9:0], b};
                    end else begin
                        mask_next = {mask_next[MASK_W-9:0], b};
                    end
                end

                cnt = header_count_reg + 4'd1;
                header_count_next = cnt;

                b0     = first_bytes_next[15:8];
                opcode = b0[3:0] & OPCODE_MASK[3:0];
                fin    = (b0 & FIN_BIT) != 8'h00;
                masked = (first_bytes_next[7:0] & MASK_BIT) != 8'h00;

                if (cnt == HDR_CHECK_CNT && opcode == OP_CLOSE) begin
                    phase_next = PH_HALT;
                    emit       = 1'b1;
                    res_kind   = KIND_CLOSE;
                end else if (cnt == HDR_CHECK_CNT &&
                             (!fin || !masked || opcode != OP_BINARY)) begin
                    phase_next = PH_HALT;
                    emit       = 1'b1;
                    res_kind   = KIND_UNSUPPORTED;
                end else if (cnt == HDR_CHECK_CNT + ext) begin
                    // Header complete (6, 8 or HDR_MAX_CNT bytes)
                    if (ext == EXT_NONE) begin
                        length_next = LENGTH_W'(len7);
                    end
                    header_count_next = '0;
                    mask_phase_next   = '0;
                    if (length_next == '0) begin
                        emit     = 1'b1;
                        res_kind = KIND_EMPTY_FRAME;
                    end else begin
                        payload_left_next = length_next;
                        phase_next        = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                // Halted: bytes are swallowed until reset
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            mask_phase_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                phase_reg        <= phase_next;
                header_count_reg <= header_count_next;
                mask_phase_reg   <= mask_phase_next;
                if (emit) begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath registers; none is read before the header writes it
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            first_bytes_reg  <= first_bytes_next;
            length_reg       <= length_next;
            mask_reg         <= mask_next;
            payload_left_reg <= payload_left_next;
            if (emit) begin
                out_data_reg <= {res_len, res_byte};
                out_kind_reg <= res_kind;
                out_last_reg <= res_last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule
